### rtl/one_wire_bus_master_assert.svh
// ============================================================================
// One-wire bus master assertion macros
// Concurrent assertion shorthands, removed when SYNTHESIS is defined.
// ============================================================================
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define OWB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one_wire_bus_master: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OWB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one_wire_bus_master: assertion failed");

`else

`define OWB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OWB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/owb_pkg.sv
// ============================================================================
// One-wire bus master package
// Shared types, command codes, register indices and reset values.
// ============================================================================
package owb_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 10;
    localparam int QUEUE_DEPTH         = 2;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int CFG_DATA_WIDTH      = 10;

    localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
    localparam logic [9:0] PRESENCE_WAIT_DEFAULT = 10'd80;
    localparam logic [9:0] RESET_TAIL_DEFAULT    = 10'd400;
    localparam logic [5:0] WRITE_ONE_LOW_DEFAULT = 6'd1;
    localparam logic [7:0] SLOT_DEFAULT          = 8'd60;
    localparam logic [5:0] READ_LOW_DEFAULT      = 6'd2;
    localparam logic [5:0] RECOVERY_DEFAULT      = 6'd1;

    typedef enum logic [1:0] {
        FUNC_RESET = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_RESET,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_WRITE_ONE_LOW = 3'd3,
        REG_SLOT          = 3'd4,
        REG_READ_LOW      = 3'd5,
        REG_RECOVERY      = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [9:0] presence_wait;
        logic [9:0] reset_tail;
        logic [5:0] write_one_low;
        logic [7:0] slot;
        logic [5:0] read_low;
        logic [5:0] recovery;
    } cfg_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] write_byte;
        logic       line_level;
    } entry_t;

endpackage

### rtl/owb_front.sv
// ============================================================================
// One-wire bus master front end
// Classifies each incoming tick into a queue entry with a decoded operation.
// ============================================================================
module owb_front
(
    input  logic                cmd_valid,
    input  logic [1:0]          func,
    input  logic [7:0]          write_byte,
    input  logic                line_level,
    output owb_pkg::entry_t     entry
);
    import owb_pkg::*;

    always_comb
    begin
        entry.write_byte = write_byte;
        entry.line_level = line_level;
        entry.op         = OP_NONE;
        if (cmd_valid)
        begin
            case (func)
                FUNC_RESET: entry.op = OP_RESET;
                FUNC_WRITE: entry.op = OP_WRITE;
                FUNC_READ:  entry.op = OP_READ;
                default:    entry.op = OP_NONE;
            endcase
        end
    end

endmodule

### rtl/owb_queue.sv
// ============================================================================
// One-wire bus master tick queue
// Short first-in first-out buffer between the front end and the sequencer.
// ============================================================================
module owb_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  owb_pkg::entry_t     push_entry,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output owb_pkg::entry_t     head
);
    import owb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/owb_back.sv
// ============================================================================
// One-wire bus master sequencer
// Runs the reset, write and read phases, one queued tick per cycle while the
// output is not stalled, into an output register.
// ============================================================================
module owb_back
#(
    parameter int COUNT_WIDTH = owb_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  owb_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  owb_pkg::entry_t     q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                drive_low,
    output logic                busy_res,
    output logic                done_res,
    output logic                presence_found,
    output logic [7:0]          read_byte
);
    import owb_pkg::*;

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_RST_LOW   = 10'b00_0000_0010,
        PH_RST_WAIT  = 10'b00_0000_0100,
        PH_RST_TAIL  = 10'b00_0000_1000,
        PH_WR_LOW    = 10'b00_0001_0000,
        PH_WR_HIGH   = 10'b00_0010_0000,
        PH_WR_REC    = 10'b00_0100_0000,
        PH_RD_LOW    = 10'b00_1000_0000,
        PH_RD_SAMPLE = 10'b01_0000_0000,
        PH_RD_WAIT   = 10'b10_0000_0000
    } phase_t;

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    function automatic logic [COUNT_WIDTH-1:0] sat(input logic [9:0] n);
        logic [COUNT_WIDTH-1:0] r;
        if (32'(n) > 32'(CMAX))
        begin
            r = CMAX;
        end
        else
        begin
            r = COUNT_WIDTH'(n);
        end
        return r;
    endfunction

    function automatic logic [9:0] at_least_one(input logic [9:0] n);
        return (n == '0) ? 10'd1 : n;
    endfunction

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [2:0]             bit_reg;
    logic [2:0]             bit_next;
    logic [7:0]             shift_reg;
    logic [7:0]             shift_next;
    op_t                    op_reg;
    op_t                    op_next;
    logic                   pres_reg;
    logic                   pres_next;
    logic [7:0]             hold_reg;
    logic [7:0]             hold_next;
    logic                   drive_next;
    logic                   busy_next;
    logic                   done_next;
    logic                   out_valid_reg;
    logic                   drive_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [COUNT_WIDTH-1:0] len_rst_low;
    logic [COUNT_WIDTH-1:0] len_pres;
    logic [COUNT_WIDTH-1:0] len_tail;
    logic [COUNT_WIDTH-1:0] len_one;
    logic [COUNT_WIDTH-1:0] len_slot;
    logic [COUNT_WIDTH-1:0] len_rd_low;
    logic [COUNT_WIDTH-1:0] len_rec;

    assign len_rst_low = sat(at_least_one(cfg.reset_low));
    assign len_pres    = sat(at_least_one(cfg.presence_wait));
    assign len_tail    = sat(cfg.reset_tail);
    assign len_one     = sat(at_least_one({4'd0, cfg.write_one_low}));
    assign len_slot    = sat(at_least_one({2'd0, cfg.slot}));
    assign len_rd_low  = sat(at_least_one({4'd0, cfg.read_low}));
    assign len_rec     = sat({4'd0, cfg.recovery});

    assign q_pop          = q_valid && (!out_valid_reg || out_ready);
    assign out_valid      = out_valid_reg;
    assign drive_low      = drive_reg;
    assign busy_res       = busy_reg;
    assign done_res       = done_reg;
    assign presence_found = pres_reg;
    assign read_byte      = hold_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        op_next    = op_reg;
        pres_next  = pres_reg;
        hold_next  = hold_reg;
        drive_next = 1'b0;
        busy_next  = 1'b0;
        done_next  = 1'b0;

        if (phase_next == PH_IDLE && q_head.op != OP_NONE)
        begin
            op_next  = q_head.op;
            bit_next = 3'd0;
            case (q_head.op)
                OP_RESET:
                begin
                    shift_next = 8'd0;
                    phase_next = PH_RST_LOW;
                    cnt_next   = len_rst_low;
                end
                OP_WRITE:
                begin
                    shift_next = q_head.write_byte;
                    phase_next = PH_WR_LOW;
                    cnt_next   = q_head.write_byte[0] ? len_one : len_slot;
                end
                OP_READ:
                begin
                    shift_next = 8'd0;
                    phase_next = PH_RD_LOW;
                    cnt_next   = len_rd_low;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (phase_next != PH_IDLE)
        begin
            busy_next  = 1'b1;
            drive_next = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW)
                         || (phase_next == PH_RD_LOW);
            if (phase_next == PH_RST_WAIT && cnt_next <= COUNT_WIDTH'(1))
            begin
                pres_next = !q_head.line_level;
            end
            if (phase_next == PH_RD_SAMPLE)
            begin
                shift_next[bit_next] = shift_next[bit_next] | q_head.line_level;
            end
            if (cnt_next != '0)
            begin
                cnt_next = cnt_next - 1'b1;
            end
            if (cnt_next == '0)
            begin
                case (phase_next)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                        cnt_next   = len_pres;
                    end
                    PH_RST_WAIT:
                    begin
                        if (len_tail != '0)
                        begin
                            phase_next = PH_RST_TAIL;
                            cnt_next   = len_tail;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WR_LOW, PH_WR_HIGH, PH_WR_REC:
                    begin
                        if (phase_next == PH_WR_LOW && shift_next[bit_next])
                        begin
                            phase_next = PH_WR_HIGH;
                            cnt_next   = len_slot;
                        end
                        else if (phase_next == PH_WR_LOW && len_rec != '0)
                        begin
                            phase_next = PH_WR_REC;
                            cnt_next   = len_rec;
                        end
                        else if (bit_next == 3'd7)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            bit_next   = bit_next + 1'b1;
                            phase_next = PH_WR_LOW;
                            cnt_next   = shift_next[bit_next] ? len_one : len_slot;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_SAMPLE;
                        cnt_next   = COUNT_WIDTH'(1);
                    end
                    PH_RD_SAMPLE:
                    begin
                        phase_next = PH_RD_WAIT;
                        cnt_next   = len_slot;
                    end
                    PH_RD_WAIT:
                    begin
                        if (bit_next == 3'd7)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            bit_next   = bit_next + 1'b1;
                            phase_next = PH_RD_LOW;
                            cnt_next   = len_rd_low;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
                if (phase_next == PH_IDLE)
                begin
                    done_next = 1'b1;
                    if (op_next == OP_READ)
                    begin
                        hold_next = shift_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            op_reg        <= OP_NONE;
            pres_reg      <= 1'b0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                op_reg        <= op_next;
                pres_reg      <= pres_next;
                hold_reg      <= hold_next;
                drive_reg     <= drive_next;
                busy_reg      <= busy_next;
                done_reg      <= done_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/one_wire_bus_master.sv
// ============================================================================
// One-wire bus master
// Tick-paced bus master for reset and presence, byte write and byte read.
// ============================================================================
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  -------------------------------
//  in        request    in_valid / in_ready    cmd_valid, func, write_byte,
//                                              line_level
//  out       result     out_valid / out_ready  drive_low, busy_res, done_res,
//                                              presence_found, read_byte
//  cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One request is taken per clock while the queue is not full; it passes
//  through the queue before its result is registered in the output register.
//  A two-entry queue separates the front end from the sequencer, so a stalled
//  output holds up to two further requests before in_ready falls.
//  Reset clears the sequencer to idle and loads the default timings.
//  Configuration writes are accepted only while the queue is empty.
//
`include "one_wire_bus_master_assert.svh"

module one_wire_bus_master
#(
    parameter int COUNT_WIDTH = owb_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    cmd_valid,
    input  logic [1:0]                              func,
    input  logic [7:0]                              write_byte,
    input  logic                                    line_level,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    drive_low,
    output logic                                    busy_res,
    output logic                                    done_res,
    output logic                                    presence_found,
    output logic [7:0]                              read_byte,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [owb_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [owb_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);
    import owb_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    entry_t     front_entry;
    entry_t     q_head;
    logic       q_not_full;
    logic       q_not_empty;
    logic       q_pop;
    logic       in_fire;

    assign cfg_ready = !q_not_empty;
    assign in_ready  = q_not_full;
    assign in_fire   = in_valid && q_not_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RESET_LOW:     cfg_next.reset_low     = cfg_data;
                REG_PRESENCE_WAIT: cfg_next.presence_wait = cfg_data;
                REG_RESET_TAIL:    cfg_next.reset_tail    = cfg_data;
                REG_WRITE_ONE_LOW: cfg_next.write_one_low = cfg_data[5:0];
                REG_SLOT:          cfg_next.slot          = cfg_data[7:0];
                REG_READ_LOW:      cfg_next.read_low      = cfg_data[5:0];
                REG_RECOVERY:      cfg_next.recovery      = cfg_data[5:0];
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low     <= RESET_LOW_DEFAULT;
            cfg_reg.presence_wait <= PRESENCE_WAIT_DEFAULT;
            cfg_reg.reset_tail    <= RESET_TAIL_DEFAULT;
            cfg_reg.write_one_low <= WRITE_ONE_LOW_DEFAULT;
            cfg_reg.slot          <= SLOT_DEFAULT;
            cfg_reg.read_low      <= READ_LOW_DEFAULT;
            cfg_reg.recovery      <= RECOVERY_DEFAULT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    owb_front u_front
    (
        .cmd_valid  (cmd_valid),
        .func       (func),
        .write_byte (write_byte),
        .line_level (line_level),
        .entry      (front_entry)
    );

    owb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire),
        .push_entry (front_entry),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    owb_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_low      (drive_low),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .presence_found (presence_found),
        .read_byte      (read_byte)
    );

    `OWB_ASSERT_SAME(a_done_is_busy, clk, rst_n, out_valid && done_res, busy_res)
    `OWB_ASSERT_SAME(a_drive_is_busy, clk, rst_n, out_valid && drive_low, busy_res)
    `OWB_ASSERT_SAME(a_stall_needs_queue, clk, rst_n, !in_ready, q_not_empty)
    `OWB_ASSERT_NEXT(a_push_held, clk, rst_n, in_fire && !q_pop, q_not_empty)

endmodule

### bench/owb_tick_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// One-wire bus master tick checker
// Watches the request, result and register channels. Every accepted request
// is one bus tick, so the checker runs its own copy of the bus sequencer on
// each one, queues the tick result that it predicts, and compares each
// accepted result with the oldest prediction. The mismatch count and the
// number of predictions still waiting are handed to the testbench top.
// ============================================================================
module owb_tick_checker
#(
    parameter int COUNT_WIDTH = owb_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                cmd_valid,
    input  logic [1:0]                          func,
    input  logic [7:0]                          write_byte,
    input  logic                                line_level,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                drive_low,
    input  logic                                busy_res,
    input  logic                                done_res,
    input  logic                                presence_found,
    input  logic [7:0]                          read_byte,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [owb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [owb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  pending_count
);
    import owb_pkg::*;

    localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH) - 1;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_RST_TAIL,
        SEQ_WR_LOW,
        SEQ_WR_HIGH,
        SEQ_WR_REC,
        SEQ_RD_LOW,
        SEQ_RD_SAMPLE,
        SEQ_RD_WAIT
    } seq_t;

    typedef struct packed {
        logic       drive;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] rdata;
    } tick_result_t;

    cfg_t         timings;
    seq_t         seq;
    int unsigned  left;
    logic [2:0]   bit_no;
    logic [7:0]   shifter;
    func_t        job;
    logic         presence;
    logic [7:0]   read_hold;
    tick_result_t expected_ticks[$];
    int           mismatches;

    function automatic int unsigned min_one(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int unsigned span(input seq_t s);
        int unsigned n;
        case (s)
            SEQ_RST_LOW:   n = min_one(timings.reset_low);
            SEQ_RST_WAIT:  n = min_one(timings.presence_wait);
            SEQ_RST_TAIL:  n = timings.reset_tail;
            SEQ_WR_LOW:    n = shifter[bit_no] ? min_one(timings.write_one_low)
                                               : min_one(timings.slot);
            SEQ_WR_HIGH:   n = min_one(timings.slot);
            SEQ_WR_REC:    n = timings.recovery;
            SEQ_RD_LOW:    n = min_one(timings.read_low);
            SEQ_RD_SAMPLE: n = 1;
            SEQ_RD_WAIT:   n = min_one(timings.slot);
            default:       n = 0;
        endcase
        return (n > COUNT_MAX) ? COUNT_MAX : n;
    endfunction

    function automatic seq_t next_bit(input seq_t first);
        seq_t s;
        if (bit_no == 3'd7)
        begin
            s = SEQ_IDLE;
        end
        else
        begin
            bit_no = bit_no + 3'd1;
            s = first;
        end
        return s;
    endfunction

    // Phases of zero length are passed over until one with a length is found.
    function automatic seq_t enter_next(input seq_t from);
        seq_t        s;
        seq_t        n;
        int unsigned len;
        s = from;
        do
        begin
            case (s)
                SEQ_RST_LOW:             n = SEQ_RST_WAIT;
                SEQ_RST_WAIT:            n = SEQ_RST_TAIL;
                SEQ_WR_LOW:              n = shifter[bit_no] ? SEQ_WR_HIGH : SEQ_WR_REC;
                SEQ_WR_HIGH, SEQ_WR_REC: n = next_bit(SEQ_WR_LOW);
                SEQ_RD_LOW:              n = SEQ_RD_SAMPLE;
                SEQ_RD_SAMPLE:           n = SEQ_RD_WAIT;
                SEQ_RD_WAIT:             n = next_bit(SEQ_RD_LOW);
                default:                 n = SEQ_IDLE;
            endcase
            len = (n == SEQ_IDLE) ? 1 : span(n);
            s = n;
        end
        while (len == 0);
        if (s != SEQ_IDLE)
        begin
            left = len;
        end
        return s;
    endfunction

    function automatic void predict_tick(input logic cv, input logic [1:0] f,
                                         input logic [7:0] wb, input logic lvl);
        tick_result_t e;
        e = '0;
        if (seq == SEQ_IDLE && cv && (f == FUNC_RESET || f == FUNC_WRITE || f == FUNC_READ))
        begin
            job = func_t'(f);
            bit_no = '0;
            shifter = (f == FUNC_WRITE) ? wb : 8'h00;
            seq = (f == FUNC_RESET) ? SEQ_RST_LOW : (f == FUNC_WRITE) ? SEQ_WR_LOW : SEQ_RD_LOW;
            left = span(seq);
        end
        if (seq != SEQ_IDLE)
        begin
            e.busy = 1'b1;
            e.drive = (seq == SEQ_RST_LOW || seq == SEQ_WR_LOW || seq == SEQ_RD_LOW);
            if (seq == SEQ_RST_WAIT && left <= 1)
            begin
                presence = !lvl;
            end
            if (seq == SEQ_RD_SAMPLE)
            begin
                shifter[bit_no] = shifter[bit_no] | lvl;
            end
            if (left > 0)
            begin
                left--;
            end
            if (left == 0)
            begin
                seq = enter_next(seq);
                if (seq == SEQ_IDLE)
                begin
                    e.done = 1'b1;
                    if (job == FUNC_READ)
                    begin
                        read_hold = shifter;
                    end
                end
            end
        end
        e.presence = presence;
        e.rdata = read_hold;
        expected_ticks.push_back(e);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_result_t want;
        if (!rst_n)
        begin
            timings = {RESET_LOW_DEFAULT, PRESENCE_WAIT_DEFAULT, RESET_TAIL_DEFAULT,
                       WRITE_ONE_LOW_DEFAULT, SLOT_DEFAULT, READ_LOW_DEFAULT,
                       RECOVERY_DEFAULT};
            seq = SEQ_IDLE;
            left = 0;
            bit_no = '0;
            shifter = '0;
            job = FUNC_RESET;
            presence = 1'b0;
            read_hold = '0;
            expected_ticks.delete();
            mismatches = 0;
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RESET_LOW:     timings.reset_low = cfg_data[9:0];
                    REG_PRESENCE_WAIT: timings.presence_wait = cfg_data[9:0];
                    REG_RESET_TAIL:    timings.reset_tail = cfg_data[9:0];
                    REG_WRITE_ONE_LOW: timings.write_one_low = cfg_data[5:0];
                    REG_SLOT:          timings.slot = cfg_data[7:0];
                    REG_READ_LOW:      timings.read_low = cfg_data[5:0];
                    REG_RECOVERY:      timings.recovery = cfg_data[5:0];
                    default:           ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_ticks.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected result: drive=%0b busy=%0b done=%0b presence=%0b read=%02h",
                                 drive_low, busy_res, done_res, presence_found, read_byte);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (drive_low !== want.drive || busy_res !== want.busy ||
                        done_res !== want.done || presence_found !== want.presence ||
                        read_byte !== want.rdata)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("tick mismatch at %0t: expected drive=%0b busy=%0b done=%0b presence=%0b read=%02h, got drive=%0b busy=%0b done=%0b presence=%0b read=%02h",
                                     $realtime, want.drive, want.busy, want.done,
                                     want.presence, want.rdata, drive_low, busy_res,
                                     done_res, presence_found, read_byte);
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_tick(cmd_valid, func, write_byte, line_level);
            end
            fail_count <= mismatches;
            pending_count <= expected_ticks.size();
        end
    end

endmodule

### bench/tb_one_wire_bus_master.sv
`timescale 1ns / 100ps
// ============================================================================
// One-wire bus master testbench
// Feeds the bus master one request per microsecond tick: first a byte write
// at the reset timings, then the shortest timings with the corner cases, and
// last random timings with random commands and line levels. Both channels
// idle at random, except in the last random phase. The checker beside the
// block predicts and compares every tick.
// ============================================================================
module tb_one_wire_bus_master;
    import owb_pkg::*;

    localparam int COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_PHASES = 3;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       cmd_valid = 1'b0;
    logic [1:0]                 func = FUNC_RESET;
    logic [7:0]                 write_byte = 8'h00;
    logic                       line_level = 1'b1;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       drive_low;
    logic                       busy_res;
    logic                       done_res;
    logic                       presence_found;
    logic [7:0]                 read_byte;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    int                         fail_count;
    int                         pending_count;
    bit                         calm = 1'b0;

    one_wire_bus_master #(.COUNT_WIDTH(COUNT_WIDTH)) DUT (.*);

    owb_tick_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    task automatic send_tick(input logic cv, input logic [1:0] f, input logic [7:0] wb,
                             input logic lvl);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd_valid <= cv;
        func <= f;
        write_byte <= wb;
        line_level <= lvl;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic random_ticks(input int count, input int cmd_pct);
        logic [1:0] f;
        for (int n = 0; n < count; n++)
        begin
            f = ($urandom_range(0, 11) == 0) ? FUNC_UNUSED
                                              : 2'($urandom_range(FUNC_RESET, FUNC_READ));
            send_tick($urandom_range(0, 99) < cmd_pct, f, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_command(input func_t f, input int ticks, input int noise_pct);
        send_tick(1'b1, f, 8'($urandom), 1'($urandom));
        random_ticks(ticks, noise_pct);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Unused upper bits of the narrower registers carry random junk.
    task automatic load_timings(input cfg_t c, input bit spare);
        logic [CFG_DATA_WIDTH-1:0] word;
        logic [CFG_DATA_WIDTH-1:0] junk;
        int                        last;
        drain();
        last = spare ? int'(REG_SPARE) : int'(REG_RECOVERY);
        cfg_valid <= 1'b1;
        for (int i = 0; i <= last; i++)
        begin
            junk = CFG_DATA_WIDTH'($urandom);
            case (i[CFG_INDEX_WIDTH-1:0])
                REG_RESET_LOW:     word = c.reset_low;
                REG_PRESENCE_WAIT: word = c.presence_wait;
                REG_RESET_TAIL:    word = c.reset_tail;
                REG_WRITE_ONE_LOW: word = {junk[9:6], c.write_one_low};
                REG_SLOT:          word = {junk[9:8], c.slot};
                REG_READ_LOW:      word = {junk[9:6], c.read_low};
                REG_RECOVERY:      word = {junk[9:6], c.recovery};
                default:           word = junk;
            endcase
            cfg_index <= i[CFG_INDEX_WIDTH-1:0];
            cfg_data <= word;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t c;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(1'b1, FUNC_UNUSED, 8'hFF, 1'b0);
        run_command(FUNC_WRITE, 495, 0);

        // Shortest timings: zero lengths are stretched to one tick or skipped.
        load_timings('0, 1'b1);
        send_tick(1'b1, FUNC_UNUSED, 8'hFF, 1'b0);
        send_tick(1'b0, FUNC_WRITE, 8'h00, 1'b1);
        send_tick(1'b1, FUNC_RESET, 8'h00, 1'b0);
        send_tick(1'b0, FUNC_RESET, 8'hFF, 1'b0);
        send_tick(1'b1, FUNC_RESET, 8'hFF, 1'b1);
        send_tick(1'b0, FUNC_READ, 8'h00, 1'b1);
        send_tick(1'b1, FUNC_WRITE, 8'h00, 1'b0);
        send_tick(1'b1, FUNC_READ, 8'hFF, 1'b1);
        random_ticks(6, 0);
        send_tick(1'b1, FUNC_WRITE, 8'hFF, 1'b1);
        random_ticks(6, 0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            c.reset_low = 10'($urandom_range(0, 6));
            c.presence_wait = 10'($urandom_range(0, 6));
            c.reset_tail = 10'($urandom_range(0, 4));
            c.write_one_low = 6'($urandom_range(0, 4));
            c.slot = 8'($urandom_range(0, 8));
            c.read_low = 6'($urandom_range(0, 4));
            c.recovery = 6'($urandom_range(0, 3));
            calm <= (p == 2);
            load_timings(c, 1'b0);
            random_ticks(100, 10);
        end
        calm <= 1'b0;

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
